FILE: rtl/qat_pkg.sv
// qat_pkg: character codes, error codes and field widths of the quoted argument tokenizer
// used by the channel interfaces and the top level; depends on nothing
`default_nettype none

package qat_pkg;

    localparam int unsigned BYTE_W = 8;
    localparam int unsigned ERR_W  = 2;

    localparam logic [BYTE_W-1:0] CH_BACKSLASH = 8'h5C;
    localparam logic [BYTE_W-1:0] CH_SQUOTE    = 8'h27;
    localparam logic [BYTE_W-1:0] CH_DQUOTE    = 8'h22;
    localparam logic [BYTE_W-1:0] CH_SPACE     = 8'h20;
    localparam logic [BYTE_W-1:0] CH_TAB       = 8'h09;
    localparam logic [BYTE_W-1:0] CH_NEWLINE   = 8'h0A;
    localparam logic [BYTE_W-1:0] CH_END       = 8'h00;

    localparam logic [ERR_W-1:0] ERR_NONE     = 2'd0;
    localparam logic [ERR_W-1:0] ERR_ESCAPE   = 2'd1;
    localparam logic [ERR_W-1:0] ERR_UNQUOTED = 2'd2;

endpackage

`default_nettype wire

FILE: rtl/qat_if.sv
// qat_char_if and qat_token_if: valid/ready channels of the tokenizer
// depends on qat_pkg for field widths
`default_nettype none

interface qat_char_if;
    logic                       valid;
    logic                       ready;
    logic [qat_pkg::BYTE_W-1:0] in_byte;

    modport source (output valid, output in_byte, input ready);
    modport sink   (input valid, input in_byte, output ready);
endinterface

interface qat_token_if;
    logic                       valid;
    logic                       ready;
    logic [qat_pkg::BYTE_W-1:0] out_byte;
    logic                       byte_valid;
    logic                       token_end;
    logic                       string_end;
    logic [qat_pkg::ERR_W-1:0]  error_code;

    modport source (output valid, output out_byte, output byte_valid, output token_end,
                    output string_end, output error_code, input ready);
    modport sink   (input valid, input out_byte, input byte_valid, input token_end,
                    input string_end, input error_code, output ready);
endinterface

`default_nettype wire

FILE: rtl/quoted_argument_tokenizer.sv
// quoted_argument_tokenizer: splits a zero-terminated byte string into shell-style arguments
// depends on qat_pkg and the channel interfaces in qat_if.sv
//
//   channel  dir  payload                                                   request
//   chars    in   in_byte                                                   one string byte
//   tokens   out  out_byte, byte_valid, token_end, string_end, error_code  one result
//
// one byte per cycle while chars.ready is high; a result appears in the output register the cycle after its byte
// quote and backslash state is updated as the byte is taken, so bytes follow back to back
// bytes that cause no result (quotes that open or close a quote, backslash, separators between tokens) pass silently
// chars.ready drops only while a result waits in the output register and tokens.ready is low
// rst_n clears the quote, escape and content flags and empties the output register
`default_nettype none

module quoted_argument_tokenizer (
    input  wire          clk,
    input  wire          rst_n,
    qat_char_if.sink     chars,
    qat_token_if.source  tokens
);

    logic sq_reg, sq_next;
    logic dq_reg, dq_next;
    logic esc_reg, esc_next;
    logic content_reg, content_next;

    logic                       out_valid_reg;
    logic [qat_pkg::BYTE_W-1:0] out_byte_reg;
    logic                       byte_valid_reg;
    logic                       token_end_reg;
    logic                       string_end_reg;
    logic [qat_pkg::ERR_W-1:0]  error_code_reg;

    logic                       emit;
    logic [qat_pkg::BYTE_W-1:0] res_byte;
    logic                       res_bvalid;
    logic                       res_tend;
    logic                       res_send;
    logic [qat_pkg::ERR_W-1:0]  res_err;

    logic in_acc;
    logic [qat_pkg::BYTE_W-1:0] c;

    assign c          = chars.in_byte;
    assign chars.ready = !out_valid_reg || tokens.ready;
    assign in_acc     = chars.valid && chars.ready;

    always_comb
    begin
        sq_next      = sq_reg;
        dq_next      = dq_reg;
        esc_next     = esc_reg;
        content_next = content_reg;
        emit         = 1'b0;
        res_byte     = c;
        res_bvalid   = 1'b1;
        res_tend     = 1'b0;
        res_send     = 1'b0;
        res_err      = qat_pkg::ERR_NONE;

        if (esc_reg)
        begin
            emit = 1'b1;
            if (c == qat_pkg::CH_END)
            begin
                sq_next      = 1'b0;
                dq_next      = 1'b0;
                esc_next     = 1'b0;
                content_next = 1'b0;
                res_byte     = '0;
                res_bvalid   = 1'b0;
                res_send     = 1'b1;
                res_err      = qat_pkg::ERR_ESCAPE;
            end
            else
            begin
                esc_next = 1'b0;
            end
        end
        else if (c == qat_pkg::CH_BACKSLASH)
        begin
            content_next = 1'b1;
            esc_next     = 1'b1;
        end
        else if (c == qat_pkg::CH_SQUOTE)
        begin
            content_next = 1'b1;
            if (!dq_reg)
                sq_next = !sq_reg;
            else
                emit = 1'b1;
        end
        else if (c == qat_pkg::CH_DQUOTE)
        begin
            content_next = 1'b1;
            if (!sq_reg)
                dq_next = !dq_reg;
            else
                emit = 1'b1;
        end
        else if (c inside {qat_pkg::CH_SPACE, qat_pkg::CH_TAB, qat_pkg::CH_NEWLINE,
                           qat_pkg::CH_END})
        begin
            if (c == qat_pkg::CH_END)
            begin
                emit         = 1'b1;
                sq_next      = 1'b0;
                dq_next      = 1'b0;
                esc_next     = 1'b0;
                content_next = 1'b0;
                res_byte     = '0;
                res_bvalid   = 1'b0;
                res_send     = 1'b1;
                if (sq_reg || dq_reg)
                    res_err  = qat_pkg::ERR_UNQUOTED;
                else
                    res_tend = content_reg;
            end
            else if (sq_reg || dq_reg)
            begin
                emit = 1'b1;
            end
            else if (content_reg)
            begin
                emit         = 1'b1;
                content_next = 1'b0;
                res_byte     = '0;
                res_bvalid   = 1'b0;
                res_tend     = 1'b1;
            end
        end
        else
        begin
            content_next = 1'b1;
            emit         = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sq_reg        <= 1'b0;
            dq_reg        <= 1'b0;
            esc_reg       <= 1'b0;
            content_reg   <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (in_acc)
            begin
                sq_reg      <= sq_next;
                dq_reg      <= dq_next;
                esc_reg     <= esc_next;
                content_reg <= content_next;
            end
            if (in_acc)
                out_valid_reg <= emit;
            else if (tokens.ready)
                out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_acc && emit)
        begin
            out_byte_reg   <= res_byte;
            byte_valid_reg <= res_bvalid;
            token_end_reg  <= res_tend;
            string_end_reg <= res_send;
            error_code_reg <= res_err;
        end
    end

    assign tokens.valid      = out_valid_reg;
    assign tokens.out_byte   = out_byte_reg;
    assign tokens.byte_valid = byte_valid_reg;
    assign tokens.token_end  = token_end_reg;
    assign tokens.string_end = string_end_reg;
    assign tokens.error_code = error_code_reg;

    // both quote modes at once is never reachable
    a_quote_excl: assert property (@(posedge clk) disable iff (!rst_n)
        !(sq_reg && dq_reg))
        else $error("single and double quote flags both set");

    a_end_clears: assert property (@(posedge clk) disable iff (!rst_n)
        (in_acc && emit && res_send) |=> !(sq_reg || dq_reg || esc_reg || content_reg))
        else $error("state not cleared after end of string");

    a_err_shape: assert property (@(posedge clk) disable iff (!rst_n)
        (tokens.valid && tokens.error_code != qat_pkg::ERR_NONE)
            |-> (tokens.string_end && !tokens.token_end && !tokens.byte_valid))
        else $error("error result with token or byte flags");

    a_blank_byte: assert property (@(posedge clk) disable iff (!rst_n)
        (tokens.valid && !tokens.byte_valid) |-> (tokens.out_byte == qat_pkg::CH_END))
        else $error("result without byte carries nonzero out_byte");

endmodule

`default_nettype wire

FILE: dv/tb_quoted_argument_tokenizer.sv
`timescale 1ns / 100ps
// tb_quoted_argument_tokenizer: self-checking bench for the shell-style argument tokenizer
// depends on qat_pkg, qat_char_if / qat_token_if and quoted_argument_tokenizer from rtl
// directed strings first, then random strings under three sender/receiver idle mixes

module tb_quoted_argument_tokenizer;

    localparam int unsigned STALL_LIMIT = 2000;
    localparam int unsigned HOLD_CYCLES = 300;

    typedef struct packed {
        logic [qat_pkg::BYTE_W-1:0] out_byte;
        logic                       byte_valid;
        logic                       token_end;
        logic                       string_end;
        logic [qat_pkg::ERR_W-1:0]  error_code;
    } token_t;

    class token_scoreboard;
        bit          in_squote;
        bit          in_dquote;
        bit          escaped;
        bit          has_content;
        token_t      expected_tokens[$];
        int unsigned mismatches;

        function void clear_state();
            in_squote   = 1'b0;
            in_dquote   = 1'b0;
            escaped     = 1'b0;
            has_content = 1'b0;
        endfunction

        function int unsigned pending();
            return expected_tokens.size();
        endfunction

        function void note_char(logic [qat_pkg::BYTE_W-1:0] c);
            token_t t;
            bit     has_result;
            bit     quoted;
            t          = '0;
            has_result = 1'b1;
            if (escaped)
            begin
                if (c == qat_pkg::CH_END)
                begin
                    clear_state();
                    t.string_end = 1'b1;
                    t.error_code = qat_pkg::ERR_ESCAPE;
                end
                else
                begin
                    escaped      = 1'b0;
                    t.out_byte   = c;
                    t.byte_valid = 1'b1;
                end
            end
            else if (c == qat_pkg::CH_BACKSLASH)
            begin
                has_content = 1'b1;
                escaped     = 1'b1;
                has_result  = 1'b0;
            end
            else if (c == qat_pkg::CH_SQUOTE && !in_dquote)
            begin
                has_content = 1'b1;
                in_squote   = !in_squote;
                has_result  = 1'b0;
            end
            else if (c == qat_pkg::CH_DQUOTE && !in_squote)
            begin
                has_content = 1'b1;
                in_dquote   = !in_dquote;
                has_result  = 1'b0;
            end
            else if (c == qat_pkg::CH_SPACE || c == qat_pkg::CH_TAB ||
                     c == qat_pkg::CH_NEWLINE || c == qat_pkg::CH_END)
            begin
                quoted = in_squote || in_dquote;
                if (c == qat_pkg::CH_END && quoted)
                begin
                    clear_state();
                    t.string_end = 1'b1;
                    t.error_code = qat_pkg::ERR_UNQUOTED;
                end
                else if (quoted)
                begin
                    t.out_byte   = c;
                    t.byte_valid = 1'b1;
                end
                else if (c == qat_pkg::CH_END)
                begin
                    t.token_end  = has_content;
                    t.string_end = 1'b1;
                    clear_state();
                end
                else if (has_content)
                begin
                    has_content = 1'b0;
                    t.token_end = 1'b1;
                end
                else
                    has_result = 1'b0;
            end
            else
            begin
                // plain character, or the other kind of quote inside quotes
                has_content  = 1'b1;
                t.out_byte   = c;
                t.byte_valid = 1'b1;
            end
            if (has_result)
                expected_tokens.push_back(t);
        endfunction

        function void report(string field, int unsigned exp_val, int unsigned act_val);
            mismatches++;
            $display("%0t: %s mismatch, expected 0x%0h, actual 0x%0h",
                     $time, field, exp_val, act_val);
        endfunction

        function void check_token(token_t got);
            token_t exp;
            if (expected_tokens.size() == 0)
            begin
                mismatches++;
                $display("%0t: unexpected result, expected none, actual 0x%0h", $time, got);
                return;
            end
            exp = expected_tokens.pop_front();
            if (got.out_byte !== exp.out_byte)
                report("out_byte", exp.out_byte, got.out_byte);
            if (got.byte_valid !== exp.byte_valid)
                report("byte_valid", exp.byte_valid, got.byte_valid);
            if (got.token_end !== exp.token_end)
                report("token_end", exp.token_end, got.token_end);
            if (got.string_end !== exp.string_end)
                report("string_end", exp.string_end, got.string_end);
            if (got.error_code !== exp.error_code)
                report("error_code", exp.error_code, got.error_code);
        endfunction
    endclass

    logic clk;
    logic rst_n;

    qat_char_if  chars_if();
    qat_token_if tokens_if();

    quoted_argument_tokenizer DUT (
        .clk    (clk),
        .rst_n  (rst_n),
        .chars  (chars_if),
        .tokens (tokens_if)
    );

    token_scoreboard sb;
    int unsigned     send_idle_pct;
    int unsigned     recv_idle_pct;
    int unsigned     chars_accepted;
    int unsigned     stall_cycles;
    bit              hold_active;
    event            hold_tokens_ev;

    always #1 clk = ~clk;

    function automatic logic [qat_pkg::BYTE_W-1:0] pick_sep();
        case ($urandom_range(2))
            0:       return qat_pkg::CH_SPACE;
            1:       return qat_pkg::CH_TAB;
            default: return qat_pkg::CH_NEWLINE;
        endcase
    endfunction

    function automatic logic [qat_pkg::BYTE_W-1:0] pick_letter();
        return 8'("a" + $urandom_range(25));
    endfunction

    function automatic void build_string(ref logic [qat_pkg::BYTE_W-1:0] s[$]);
        int                         kind;
        logic [qat_pkg::BYTE_W-1:0] q;
        kind = $urandom_range(9);
        s.delete();
        if (kind == 0)
        begin
            // noise
            repeat ($urandom_range(1, 12))
                s.push_back(8'($urandom_range(1, 255)));
        end
        else
        begin
            repeat ($urandom_range(0, 4))
            begin
                repeat ($urandom_range(0, 2))
                    s.push_back(pick_sep());
                repeat ($urandom_range(1, 5))
                begin
                    case ($urandom_range(5))
                        0: s.push_back(8'($urandom_range(1, 255)));
                        1:
                        begin
                            s.push_back(qat_pkg::CH_BACKSLASH);
                            s.push_back(8'($urandom_range(1, 255)));
                        end
                        2, 3:
                        begin
                            q = $urandom_range(1) ? qat_pkg::CH_SQUOTE : qat_pkg::CH_DQUOTE;
                            s.push_back(q);
                            repeat ($urandom_range(0, 3))
                            begin
                                case ($urandom_range(3))
                                    0: s.push_back(pick_sep());
                                    1: s.push_back(q == qat_pkg::CH_SQUOTE ?
                                                   qat_pkg::CH_DQUOTE : qat_pkg::CH_SQUOTE);
                                    2:
                                    begin
                                        s.push_back(qat_pkg::CH_BACKSLASH);
                                        s.push_back(8'($urandom_range(1, 255)));
                                    end
                                    default: s.push_back(pick_letter());
                                endcase
                            end
                            s.push_back(q);
                        end
                        default: s.push_back(pick_letter());
                    endcase
                end
            end
            repeat ($urandom_range(0, 1))
                s.push_back(pick_sep());
            // broken endings
            if (kind == 1)
                s.push_back(qat_pkg::CH_BACKSLASH);
            else if (kind == 2)
            begin
                s.push_back($urandom_range(1) ? qat_pkg::CH_SQUOTE : qat_pkg::CH_DQUOTE);
                repeat ($urandom_range(0, 2))
                    s.push_back(pick_letter());
            end
        end
        s.push_back(qat_pkg::CH_END);
    endfunction

    task automatic send_char(input logic [qat_pkg::BYTE_W-1:0] c);
        bit took;
        while ($urandom_range(99) < send_idle_pct)
        begin
            chars_if.valid <= 1'b0;
            @(posedge clk);
        end
        chars_if.valid   <= 1'b1;
        chars_if.in_byte <= c;
        do
        begin
            @(negedge clk);
            took = chars_if.ready;
            if (took)
            begin
                sb.note_char(c);
                chars_accepted++;
            end
            @(posedge clk);
        end
        while (!took);
    endtask

    task automatic drain();
        chars_if.valid <= 1'b0;
        @(posedge clk);
        while (sb.pending() != 0)
            @(posedge clk);
    endtask

    task automatic run_phase(input int unsigned s_pct, input int unsigned r_pct,
                             input int unsigned n_chars);
        logic [qat_pkg::BYTE_W-1:0] s[$];
        int unsigned                stop_at;
        send_idle_pct = s_pct;
        recv_idle_pct = r_pct;
        stop_at       = chars_accepted + n_chars;
        while (chars_accepted < stop_at)
        begin
            build_string(s);
            foreach (s[i])
                send_char(s[i]);
        end
        drain();
    endtask

    // receiver ready
    initial
    begin
        forever
        begin
            @(posedge clk);
            tokens_if.ready <= rst_n && !hold_active && ($urandom_range(99) >= recv_idle_pct);
        end
    end

    // long receiver hold-off
    initial
    begin
        forever
        begin
            @(hold_tokens_ev);
            hold_active = 1'b1;
            repeat (HOLD_CYCLES) @(posedge clk);
            hold_active = 1'b0;
        end
    end

    // result monitor
    initial
    begin
        token_t got;
        forever
        begin
            @(negedge clk);
            if (rst_n && tokens_if.valid === 1'b1 && tokens_if.ready === 1'b1)
            begin
                got = {tokens_if.out_byte, tokens_if.byte_valid, tokens_if.token_end,
                       tokens_if.string_end, tokens_if.error_code};
                @(posedge clk);
                sb.check_token(got);
            end
        end
    end

    // watchdog
    always @(negedge clk)
    begin
        if ((chars_if.valid === 1'b1 && chars_if.ready === 1'b1) ||
            (tokens_if.valid === 1'b1 && tokens_if.ready === 1'b1))
            stall_cycles = 0;
        else
            stall_cycles++;
        if (stall_cycles >= STALL_LIMIT)
        begin
            $display("%0t: no request accepted for %0d cycles", $time, stall_cycles);
            $display("[quoted_argument_tokenizer] ERROR");
            $finish;
        end
    end

    initial
    begin
        logic [qat_pkg::BYTE_W-1:0] directed[$];
        sb               = new();
        clk              = 1'b0;
        rst_n            = 1'b0;
        chars_if.valid   = 1'b0;
        chars_if.in_byte = '0;
        tokens_if.ready  = 1'b0;
        hold_active      = 1'b0;
        send_idle_pct    = 0;
        recv_idle_pct    = 0;
        chars_accepted   = 0;
        stall_cycles     = 0;
        sb.clear_state();

        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // extremes and separators, empty token at end
        directed = '{"a", 8'hFF, qat_pkg::CH_TAB, qat_pkg::CH_TAB, 8'h01,
                     qat_pkg::CH_NEWLINE, qat_pkg::CH_END,
        // quotes inside the other kind, escape inside single quotes
                     qat_pkg::CH_SQUOTE, qat_pkg::CH_DQUOTE, qat_pkg::CH_BACKSLASH,
                     qat_pkg::CH_SQUOTE, qat_pkg::CH_SQUOTE, qat_pkg::CH_SPACE,
                     qat_pkg::CH_DQUOTE, qat_pkg::CH_SQUOTE, qat_pkg::CH_DQUOTE,
                     qat_pkg::CH_END,
        // empty quotes
                     qat_pkg::CH_DQUOTE, qat_pkg::CH_DQUOTE, qat_pkg::CH_END,
        // trailing backslash
                     "x", qat_pkg::CH_BACKSLASH, qat_pkg::CH_END,
        // unterminated quote with quoted space
                     qat_pkg::CH_DQUOTE, qat_pkg::CH_SPACE, qat_pkg::CH_END};
        send_idle_pct = 18;
        recv_idle_pct = 76;
        foreach (directed[i])
            send_char(directed[i]);
        drain();

        run_phase(18, 76, 210);
        run_phase(76, 18, 210);
        -> hold_tokens_ev;
        run_phase(0, 0, 210);

        repeat (20) @(posedge clk);
        if (sb.pending() != 0)
            $display("%0t: %0d expected results never arrived", $time, sb.pending());
        if (sb.mismatches == 0 && sb.pending() == 0)
            $display("[quoted_argument_tokenizer] OK");
        else
            $display("[quoted_argument_tokenizer] ERROR");
        $finish;
    end

endmodule
